// ===== src/pcmfc_pkg.sv =====
package pcmfc_pkg;

    typedef enum logic [1:0] {
        FMT_LIN16 = 2'd0,
        FMT_LIN8  = 2'd1,
        FMT_ULAW  = 2'd2,
        FMT_ALAW  = 2'd3
    } t_fmt;

    localparam int unsigned MAG_W = 14;
    localparam int unsigned NUM_SEG = 8;

    localparam logic [MAG_W-1:0] MU_CLIP = 14'd8159;
    localparam logic [MAG_W-1:0] MU_BIAS = 14'd33;

    localparam logic [7:0] LIN8_OFFSET = 8'h80;
    localparam logic [7:0] MU_MASK_POS = 8'hFF;
    localparam logic [7:0] MU_MASK_NEG = 8'h7F;
    localparam logic [7:0] A_MASK_POS  = 8'hD5;
    localparam logic [7:0] A_MASK_NEG  = 8'h55;
    localparam logic [7:0] SEG_OVER    = 8'h7F;

    typedef logic [MAG_W-1:0] t_seg_tab [NUM_SEG];

    localparam t_seg_tab MU_SEG_END = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };

    localparam t_seg_tab A_SEG_END = '{
        14'h001F, 14'h003F, 14'h007F, 14'h00FF,
        14'h01FF, 14'h03FF, 14'h07FF, 14'h0FFF
    };

    // first segment whose end is not below v, NUM_SEG when none
    function automatic logic [3:0] seg_find(input logic [MAG_W-1:0] v,
                                            input t_seg_tab tab);
        logic [3:0] seg;
        seg = 4'(NUM_SEG);
        for (int i = NUM_SEG - 1; i >= 0; i--) begin
            if (v <= tab[i]) begin
                seg = 4'(i);
            end
        end
        return seg;
    endfunction

endpackage

// ===== src/pcm16_sample_format_converter.sv =====
// pipeline: a transaction accepted at one clock edge passes through the stage 1,
//   stage 2 and stage 3 registers before its result strobe appears
// throughput: one sample per cycle, set by the three-stage encode pipeline
// busy never rises and the receiver cannot stall, so nothing is held back
// reset: synchronous active-low; clears the stage valid bits and sets the
//   output format to linear16
module pcm16_sample_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] i_sample,
    input  logic        i_silence,
    input  logic        i_last_in,
    output logic        o_valid,
    output logic [15:0] o_coded_word,
    output logic        o_is_byte,
    output logic        o_last_out
);
    import pcmfc_pkg::*;

    t_fmt r_output_format;

    // stage 1: captured sample
    logic        r1_vld;
    logic [15:0] r1_raw;
    t_fmt        r1_fmt;
    logic        r1_last;

    // stage 2: sign and magnitude
    logic             r2_vld;
    logic [15:0]      r2_raw;
    t_fmt             r2_fmt;
    logic             r2_last;
    logic             r2_neg;
    logic [MAG_W-1:0] r2_mag;
    logic [MAG_W-1:0] n2_mag;

    // stage 3: output registers
    logic        r3_vld;
    logic [15:0] r3_word;
    logic        r3_is_byte;
    logic        r3_last;
    logic [15:0] n3_word;

    logic              accept;
    logic signed [13:0] mu_lin;
    logic signed [12:0] a_lin;
    logic [14:0]       mu_abs;
    logic [MAG_W-1:0]  mu_clip;

    logic [3:0]       mu_seg;
    logic [3:0]       a_seg;
    logic [MAG_W-1:0] mu_shift;
    logic [MAG_W-1:0] a_shift;
    logic [3:0]       a_mant;
    logic [7:0]       mu_code;
    logic [7:0]       a_code;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_format <= FMT_LIN16;
        end else if (i_cfg_wr_en) begin
            r_output_format <= t_fmt'(i_cfg_wr_data);
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
        r1_raw  <= i_silence ? 16'h0000 : i_sample;
        r1_fmt  <= r_output_format;
        r1_last <= i_last_in;
    end

    // stage 2: mu-law works on 14 bits, a-law on 13
    always_comb begin
        mu_lin = $signed(r1_raw[15:2]);
        a_lin  = $signed(r1_raw[15:3]);
        if (mu_lin < 0) begin
            mu_abs = 15'(-$signed({mu_lin[13], mu_lin}));
        end else begin
            mu_abs = {1'b0, mu_lin};
        end
        mu_clip = (mu_abs > {1'b0, MU_CLIP}) ? MU_CLIP : mu_abs[MAG_W-1:0];
        if (r1_fmt == FMT_ALAW) begin
            // one's complement of a negative value gives -v-1
            n2_mag = {2'b00, (a_lin[12] ? ~a_lin[11:0] : a_lin[11:0])};
        end else begin
            n2_mag = mu_clip + MU_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_raw  <= r1_raw;
        r2_fmt  <= r1_fmt;
        r2_last <= r1_last;
        r2_neg  <= r1_raw[15];
        r2_mag  <= n2_mag;
    end

    // stage 3: segment search and code assembly
    always_comb begin
        mu_seg   = seg_find(r2_mag, MU_SEG_END);
        a_seg    = seg_find(r2_mag, A_SEG_END);
        mu_shift = r2_mag >> (mu_seg + 4'd1);
        a_shift  = r2_mag >> a_seg;
        a_mant   = (a_seg < 4'd2) ? r2_mag[4:1] : a_shift[3:0];

        if (mu_seg == 4'(NUM_SEG)) begin
            // biased magnitude past the top segment
            mu_code = SEG_OVER ^ (r2_neg ? MU_MASK_NEG : MU_MASK_POS);
        end else begin
            mu_code = {1'b0, mu_seg[2:0], mu_shift[3:0]}
                      ^ (r2_neg ? MU_MASK_NEG : MU_MASK_POS);
        end
        a_code = {1'b0, a_seg[2:0], a_mant} ^ (r2_neg ? A_MASK_NEG : A_MASK_POS);

        case (r2_fmt)
            FMT_LIN16: n3_word = r2_raw;
            FMT_LIN8:  n3_word = {8'h00, r2_raw[15:8] ^ LIN8_OFFSET};
            FMT_ULAW:  n3_word = {8'h00, mu_code};
            FMT_ALAW:  n3_word = {8'h00, a_code};
            default:   n3_word = r2_raw;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_word    <= n3_word;
        r3_is_byte <= (r2_fmt != FMT_LIN16);
        r3_last    <= r2_last;
    end

    assign o_valid      = r3_vld;
    assign o_coded_word = r3_word;
    assign o_is_byte    = r3_is_byte;
    assign o_last_out   = r3_last;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("accepted transaction did not reach the output");

    a_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_byte) |-> (o_coded_word[15:8] == 8'h00))
        else $error("byte code with nonzero upper bits");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_out == $past(i_last_in, 3)))
        else $error("last marker out of step with its sample");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result strobe without an accepted transaction");

endmodule
